/* design/tpsm_pkg.sv */
// ----------------------------------------------------------------------------
// Turnout position and stall monitor package
// Shared types, codes and reset constants of the monitor.
// ----------------------------------------------------------------------------
package tpsm_pkg;

  localparam int unsigned TPSM_CHANNELS = 3;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned PWM_W      = 16;
  localparam int unsigned LIMIT_W    = 17;
  localparam int unsigned CHAN_W     = 3;
  localparam int unsigned CONTACT_W  = 8;

  localparam logic [CFG_DATA_W-1:0] REPORT_PERIOD_RST = 16'd200;
  localparam logic [CFG_DATA_W-1:0] UNKNOWN_LIMIT_RST = 16'd800;
  localparam logic [CFG_DATA_W-1:0] MIN_TRAVEL_RST    = 16'd200;
  localparam logic [CFG_DATA_W-1:0] MAX_TRAVEL_RST    = 16'd1500;
  localparam logic [CFG_DATA_W-1:0] MARGIN_RST        = 16'd200;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REPORT_PERIOD = 3'd0,
    CFG_UNKNOWN_LIMIT = 3'd1,
    CFG_MIN_TRAVEL    = 3'd2,
    CFG_MAX_TRAVEL    = 3'd3,
    CFG_MARGIN        = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_MOVE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    POS_STRAIGHT = 2'd0,
    POS_DIVERTED = 2'd1,
    POS_UNDET    = 2'd2,
    POS_INCONS   = 2'd3
  } pos_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_BLOCKED = 2'd1,
    STAT_ERROR   = 2'd2
  } status_e;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INC,
    S_EL_SUB,
    S_EL_CMP,
    S_RP_SUB,
    S_RP_CMP,
    S_UPD,
    S_EMIT,
    S_MV_SUB,
    S_MV_NEG,
    S_MV_MIN,
    S_MV_MAX,
    S_MV_ADD
  } state_e;

  typedef struct packed {
    alu_op_e           op;
    logic [TIME_W-1:0] a;
    logic [TIME_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [TIME_W-1:0] res;
    logic              borrow;
  } alu_rsp_t;

endpackage

/* design/tpsm_if.sv */
// ----------------------------------------------------------------------------
// Turnout position and stall monitor channels
// Valid/ready interfaces for input words and report words.
// ----------------------------------------------------------------------------
interface tpsm_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [7:0]  straight_pressed;
  logic [7:0]  diverted_pressed;
  logic [2:0]  channel;
  logic [15:0] current_pwm;
  logic [15:0] target_pwm;

  modport source (
    output valid, cmd, straight_pressed, diverted_pressed, channel, current_pwm,
           target_pwm,
    input  ready
  );
  modport sink (
    input  valid, cmd, straight_pressed, diverted_pressed, channel, current_pwm,
           target_pwm,
    output ready
  );
endinterface

interface tpsm_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] report_channel;
  logic [1:0] position;
  logic [1:0] status;
  logic       last;

  modport source (
    output valid, report_channel, position, status, last,
    input  ready
  );
  modport sink (
    input  valid, report_channel, position, status, last,
    output ready
  );
endinterface

/* design/tpsm_alu.sv */
// ----------------------------------------------------------------------------
// Turnout position and stall monitor shared arithmetic unit
// One 32-bit adder/subtractor with borrow, used by every arithmetic step of the sequencer.
// ----------------------------------------------------------------------------
module tpsm_alu (
  input  tpsm_pkg::alu_req_t req_i,
  output tpsm_pkg::alu_rsp_t rsp_o
);
  import tpsm_pkg::*;

  logic              sub;
  logic [TIME_W:0]   sum;
  logic [TIME_W-1:0] b_inv;

  assign sub   = (req_i.op == ALU_SUB);
  assign b_inv = req_i.b ^ {TIME_W{sub}};
  assign sum   = {1'b0, req_i.a} + {1'b0, b_inv} + {{TIME_W{1'b0}}, sub};

  assign rsp_o.res    = sum[TIME_W-1:0];
  assign rsp_o.borrow = sub & ~sum[TIME_W];

endmodule

/* design/turnout_position_stall_monitor_core.sv */
// ----------------------------------------------------------------------------
// Turnout position and stall monitor
// Decodes limit contacts, times point movements and issues report words.
// ----------------------------------------------------------------------------
//  Channel  Dir  Word
//  in_i     in   cmd, contact bits, channel, current and target pulse width
//  out_o    out  report channel, position, status, last
//  cfg      in   write enable, register index, 16-bit data
//
//  A tick holds off the next input word until every channel has been checked
//  and its report words loaded, also while a report word waits on out_o.ready;
//  the shared adder makes the steps run one after another.
//  A movement start runs the subtract, negate, minimum, maximum and add steps,
//  or none when a pulse width is zero or the channel is out of range. Reset is
//  asynchronous and resets the control and settings registers, not the data ones.
module turnout_position_stall_monitor_core #(
  parameter int unsigned CHANNELS = tpsm_pkg::TPSM_CHANNELS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  tpsm_in_if.sink                          in_i,
  tpsm_out_if.source                       out_o,
  input  logic                             cfg_we_i,
  input  logic [tpsm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [tpsm_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import tpsm_pkg::*;

  localparam int unsigned CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [CH_IDX_W-1:0] LAST_CH = CH_IDX_W'(CHANNELS - 1);

  logic [CFG_DATA_W-1:0] period_q, unknown_q, min_q, max_q, margin_q;

  state_e state_q, state_d;

  logic [TIME_W-1:0]     now_q;
  logic [TIME_W-1:0]     move_start_q [CHANNELS];
  logic [LIMIT_W-1:0]    move_limit_q [CHANNELS];
  logic [CHANNELS-1:0]   moving_q;
  logic [CHANNELS-1:0]   rep_valid_q;
  pos_e                  rep_pos_q    [CHANNELS];
  status_e               rep_stat_q   [CHANNELS];
  logic [TIME_W-1:0]     rep_time_q   [CHANNELS];
  logic [CHANNELS-1:0]   emit_q;
  logic [CH_IDX_W-1:0]   ch_q;
  logic [CH_IDX_W-1:0]   mv_ch_q;

  logic [TIME_W-1:0]     acc_q;
  logic [PWM_W-1:0]      trav_q;
  logic                  brw_q;
  logic                  blocked_q;
  logic                  periodic_q;
  logic [CONTACT_W-1:0]  sp_q, dp_q;
  logic [PWM_W-1:0]      cur_q, tgt_q;

  logic                  out_vld_q;
  logic [CHAN_W-1:0]     out_ch_q;
  pos_e                  out_pos_q;
  status_e               out_stat_q;
  logic                  out_last_q;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  logic    in_fire, in_move, in_rng, pwm_zero, slot_free, emit_fire, emit_adv;
  logic    hi_pend, changed;
  logic [CHAN_W-1:0] ch_sel;
  pos_e    pos;
  status_e stat;

  tpsm_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid & in_i.ready;
  assign in_move    = (cmd_e'(in_i.cmd) == CMD_MOVE);
  assign in_rng     = ({1'b0, in_i.channel} < (CHAN_W + 1)'(CHANNELS));
  assign pwm_zero   = (in_i.current_pwm == '0) | (in_i.target_pwm == '0);
  assign ch_sel     = CHAN_W'(ch_q);

  assign slot_free  = ~out_vld_q | out_o.ready;
  assign emit_fire  = (state_q == S_EMIT) & emit_q[ch_q] & slot_free;
  assign emit_adv   = (state_q == S_EMIT) & (~emit_q[ch_q] | slot_free);

  always_comb begin
    hi_pend = 1'b0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (CH_IDX_W'(i) > ch_q) begin
        hi_pend = hi_pend | emit_q[i];
      end
    end
  end

  always_comb begin
    unique case ({sp_q[ch_sel], dp_q[ch_sel]})
      2'b10:   pos = POS_STRAIGHT;
      2'b01:   pos = POS_DIVERTED;
      2'b00:   pos = POS_UNDET;
      default: pos = POS_INCONS;
    endcase
    if (pos == POS_UNDET || pos == POS_INCONS) begin
      stat = STAT_ERROR;
    end else if (moving_q[ch_q] && blocked_q) begin
      stat = STAT_BLOCKED;
    end else begin
      stat = STAT_OK;
    end
    changed = ~rep_valid_q[ch_q] | (pos != rep_pos_q[ch_q]) | (stat != rep_stat_q[ch_q]);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (!in_move) begin
            state_d = S_INC;
          end else if (in_rng && !pwm_zero) begin
            state_d = S_MV_SUB;
          end
        end
      end
      S_INC:    state_d = S_EL_SUB;
      S_EL_SUB: state_d = S_EL_CMP;
      S_EL_CMP: state_d = S_RP_SUB;
      S_RP_SUB: state_d = S_RP_CMP;
      S_RP_CMP: state_d = S_UPD;
      S_UPD:    state_d = (ch_q == LAST_CH) ? S_EMIT : S_EL_SUB;
      S_EMIT: begin
        if (emit_adv && ch_q == LAST_CH) begin
          state_d = S_IDLE;
        end
      end
      S_MV_SUB: state_d = S_MV_NEG;
      S_MV_NEG: state_d = S_MV_MIN;
      S_MV_MIN: state_d = S_MV_MAX;
      S_MV_MAX: state_d = S_MV_ADD;
      S_MV_ADD: state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    alu_req.op = ALU_SUB;
    alu_req.a  = '0;
    alu_req.b  = '0;
    unique case (state_q)
      S_INC: begin
        alu_req.op = ALU_ADD;
        alu_req.a  = now_q;
        alu_req.b  = TIME_W'(1);
      end
      S_EL_SUB: begin
        alu_req.a = now_q;
        alu_req.b = move_start_q[ch_q];
      end
      S_EL_CMP: begin
        alu_req.a = TIME_W'(move_limit_q[ch_q]);
        alu_req.b = acc_q;
      end
      S_RP_SUB: begin
        alu_req.a = now_q;
        alu_req.b = rep_time_q[ch_q];
      end
      S_RP_CMP: begin
        alu_req.a = acc_q;
        alu_req.b = TIME_W'(period_q);
      end
      S_MV_SUB: begin
        alu_req.a = TIME_W'(cur_q);
        alu_req.b = TIME_W'(tgt_q);
      end
      S_MV_NEG: begin
        alu_req.a = TIME_W'(tgt_q);
        alu_req.b = TIME_W'(cur_q);
      end
      S_MV_MIN: begin
        alu_req.a = TIME_W'(trav_q);
        alu_req.b = TIME_W'(min_q);
      end
      S_MV_MAX: begin
        alu_req.a = TIME_W'(max_q);
        alu_req.b = TIME_W'(trav_q);
      end
      S_MV_ADD: begin
        alu_req.op = ALU_ADD;
        alu_req.a  = TIME_W'(trav_q);
        alu_req.b  = TIME_W'(margin_q);
      end
      default: begin
        alu_req.op = ALU_SUB;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q  <= REPORT_PERIOD_RST;
      unknown_q <= UNKNOWN_LIMIT_RST;
      min_q     <= MIN_TRAVEL_RST;
      max_q     <= MAX_TRAVEL_RST;
      margin_q  <= MARGIN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_REPORT_PERIOD: period_q  <= cfg_data_i;
        CFG_UNKNOWN_LIMIT: unknown_q <= cfg_data_i;
        CFG_MIN_TRAVEL:    min_q     <= cfg_data_i;
        CFG_MAX_TRAVEL:    max_q     <= cfg_data_i;
        CFG_MARGIN:        margin_q  <= cfg_data_i;
        default:           period_q  <= period_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      now_q       <= '0;
      moving_q    <= '0;
      rep_valid_q <= '0;
      emit_q      <= '0;
      ch_q        <= '0;
      mv_ch_q     <= '0;
      out_vld_q   <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        move_start_q[i] <= '0;
        move_limit_q[i] <= '0;
        rep_pos_q[i]    <= POS_STRAIGHT;
        rep_stat_q[i]   <= STAT_OK;
        rep_time_q[i]   <= '0;
      end
    end else begin
      state_q <= state_d;
      if (emit_fire) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire && in_move && in_rng) begin
            mv_ch_q <= in_i.channel[CH_IDX_W-1:0];
            if (pwm_zero) begin
              moving_q[in_i.channel[CH_IDX_W-1:0]]     <= 1'b1;
              move_start_q[in_i.channel[CH_IDX_W-1:0]] <= now_q;
              move_limit_q[in_i.channel[CH_IDX_W-1:0]] <= LIMIT_W'(unknown_q);
            end
          end
        end
        S_INC: begin
          now_q  <= alu_rsp.res;
          emit_q <= '0;
          ch_q   <= '0;
        end
        S_UPD: begin
          if (pos != POS_UNDET && pos != POS_INCONS && stat == STAT_OK) begin
            moving_q[ch_q] <= 1'b0;
          end
          if (changed || periodic_q) begin
            emit_q[ch_q]      <= 1'b1;
            rep_valid_q[ch_q] <= 1'b1;
            rep_pos_q[ch_q]   <= pos;
            rep_stat_q[ch_q]  <= stat;
            rep_time_q[ch_q]  <= now_q;
          end
          ch_q <= (ch_q == LAST_CH) ? '0 : ch_q + 1'b1;
        end
        S_EMIT: begin
          if (emit_adv) begin
            ch_q <= (ch_q == LAST_CH) ? '0 : ch_q + 1'b1;
          end
        end
        S_MV_ADD: begin
          moving_q[mv_ch_q]     <= 1'b1;
          move_start_q[mv_ch_q] <= now_q;
          move_limit_q[mv_ch_q] <= alu_rsp.res[LIMIT_W-1:0];
        end
        default: begin
          ch_q <= ch_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      sp_q  <= in_i.straight_pressed;
      dp_q  <= in_i.diverted_pressed;
      cur_q <= in_i.current_pwm;
      tgt_q <= in_i.target_pwm;
    end
    unique case (state_q)
      S_EL_SUB: acc_q      <= alu_rsp.res;
      S_EL_CMP: blocked_q  <= alu_rsp.borrow;
      S_RP_SUB: acc_q      <= alu_rsp.res;
      S_RP_CMP: periodic_q <= ~alu_rsp.borrow;
      S_MV_SUB: begin
        acc_q <= alu_rsp.res;
        brw_q <= alu_rsp.borrow;
      end
      S_MV_NEG: trav_q <= brw_q ? alu_rsp.res[PWM_W:1] : acc_q[PWM_W:1];
      S_MV_MIN: begin
        if (alu_rsp.borrow) begin
          trav_q <= min_q;
        end
      end
      S_MV_MAX: begin
        if (alu_rsp.borrow) begin
          trav_q <= max_q;
        end
      end
      default: begin
        brw_q <= brw_q;
      end
    endcase
    if (emit_fire) begin
      out_ch_q   <= ch_sel;
      out_pos_q  <= rep_pos_q[ch_q];
      out_stat_q <= rep_stat_q[ch_q];
      out_last_q <= ~hi_pend;
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.report_channel = out_ch_q;
  assign out_o.position       = out_pos_q;
  assign out_o.status         = out_stat_q;
  assign out_o.last           = out_last_q;

endmodule

/* sim/turnout_position_stall_monitor_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Turnout position and stall monitor testbench
// Sends tick and movement-start words with random pauses on both sides,
// predicts every report word from a behavioral copy of the monitor state and
// checks each report word field by field, across several limit settings.
// ----------------------------------------------------------------------------
module turnout_position_stall_monitor_core_tb;
  import tpsm_pkg::*;

  localparam int CH            = TPSM_CHANNELS;
  localparam int SETTLE_CYCLES = 40;
  localparam int WATCHDOG_MAX  = 2000;

  typedef struct packed {
    logic        drain;
    cmd_e        cmd;
    logic [7:0]  sp;
    logic [7:0]  dp;
    logic [2:0]  chan;
    logic [15:0] cur;
    logic [15:0] tgt;
  } word_t;

  typedef struct packed {
    logic [2:0] chan;
    pos_e       pos;
    status_e    stat;
    logic       last;
  } report_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we = 1'b0;
  cfg_idx_e   cfg_idx = CFG_REPORT_PERIOD;
  logic [15:0] cfg_data = '0;

  tpsm_in_if  in_if ();
  tpsm_out_if out_if ();

  turnout_position_stall_monitor_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  // Monitor state as the block should hold it.
  logic [15:0] period_ms, unknown_ms, min_ms, max_ms, margin_ms;
  logic [31:0] now_ms;
  logic [31:0] start_ms [CH];
  logic [16:0] limit_ms [CH];
  logic        moving   [CH];
  logic        rep_valid[CH];
  pos_e        rep_pos  [CH];
  status_e     rep_stat [CH];
  logic [31:0] rep_time [CH];

  word_t       pending_words[$];
  report_t     expected_reports[$];
  word_t       cur_word;
  logic        in_flight = 1'b0;
  logic        drv_valid;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  int unsigned idle_cycles = 0;
  int unsigned word_count = 0;
  int unsigned errors = 0;
  bit          no_gaps = 1'b0;
  logic [CH-1:0] rest_sp, rest_dp;

  function automatic int unsigned pause_len();
    return no_gaps ? 0 : $urandom_range(0, 10);
  endfunction

  function automatic logic [16:0] stall_limit(input logic [15:0] cur, input logic [15:0] tgt);
    logic [15:0] t;
    if (cur == 16'd0 || tgt == 16'd0) return {1'b0, unknown_ms};
    t = (cur > tgt) ? cur - tgt : tgt - cur;
    t = t >> 1;
    if (t < min_ms) t = min_ms;
    if (t > max_ms) t = max_ms;
    return {1'b0, t} + {1'b0, margin_ms};
  endfunction

  task automatic predict_reports(input word_t w);
    pos_e        p;
    status_e     st;
    logic [31:0] elapsed;
    int          n;
    if (w.cmd == CMD_MOVE) begin
      if (w.chan < CH) begin
        moving[w.chan]   = 1'b1;
        start_ms[w.chan] = now_ms;
        limit_ms[w.chan] = stall_limit(w.cur, w.tgt);
      end
    end else begin
      now_ms = now_ms + 32'd1;
      n = 0;
      for (int c = 0; c < CH; c++) begin
        case ({w.sp[c], w.dp[c]})
          2'b10: p = POS_STRAIGHT;
          2'b01: p = POS_DIVERTED;
          2'b00: p = POS_UNDET;
          default: p = POS_INCONS;
        endcase
        elapsed = now_ms - start_ms[c];
        if (p == POS_UNDET || p == POS_INCONS) st = STAT_ERROR;
        else if (moving[c] && elapsed > {15'd0, limit_ms[c]}) st = STAT_BLOCKED;
        else st = STAT_OK;
        if (st == STAT_OK) moving[c] = 1'b0;
        elapsed = now_ms - rep_time[c];
        if (!rep_valid[c] || p != rep_pos[c] || st != rep_stat[c] ||
            elapsed >= {16'd0, period_ms}) begin
          expected_reports.push_back('{chan: 3'(c), pos: p, stat: st, last: 1'b0});
          rep_valid[c] = 1'b1;
          rep_pos[c]   = p;
          rep_stat[c]  = st;
          rep_time[c]  = now_ms;
          n++;
        end
      end
      if (n > 0) expected_reports[expected_reports.size() - 1].last = 1'b1;
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: report %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  task automatic check_report();
    report_t want;
    if (expected_reports.size() == 0) begin
      errors++;
      $display("%0t: unexpected report word: expected none, actual ch %0d pos %0d st %0d last %0b",
               $time, out_if.report_channel, out_if.position, out_if.status, out_if.last);
    end else begin
      want = expected_reports.pop_front();
      check_field("channel", want.chan, out_if.report_channel);
      check_field("position", want.pos, out_if.position);
      check_field("status", want.stat, out_if.status);
      check_field("last", want.last, out_if.last);
    end
  endtask

  // Input word driver.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid            <= 1'b0;
      in_if.cmd              <= CMD_TICK;
      in_if.straight_pressed <= '0;
      in_if.diverted_pressed <= '0;
      in_if.channel          <= '0;
      in_if.current_pwm      <= '0;
      in_if.target_pwm       <= '0;
      in_flight = 1'b0;
      send_gap  = 0;
    end else begin
      drv_valid = in_if.valid;
      if (in_if.valid && in_if.ready) begin
        predict_reports(cur_word);
        in_flight = 1'b0;
        drv_valid = 1'b0;
        send_gap  = pause_len();
      end
      if (!drv_valid) begin
        if (send_gap != 0) begin
          send_gap--;
        end else if (pending_words.size() != 0 &&
                     !(pending_words[0].drain && expected_reports.size() != 0)) begin
          cur_word  = pending_words.pop_front();
          in_flight = 1'b1;
          drv_valid = 1'b1;
          in_if.cmd              <= cur_word.cmd;
          in_if.straight_pressed <= cur_word.sp;
          in_if.diverted_pressed <= cur_word.dp;
          in_if.channel          <= cur_word.chan;
          in_if.current_pwm      <= cur_word.cur;
          in_if.target_pwm       <= cur_word.tgt;
        end
      end
      in_if.valid <= drv_valid;
    end
  end

  // Report word monitor.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        check_report();
        recv_gap = pause_len();
      end
      if (recv_gap != 0) begin
        recv_gap--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_MAX) begin
      $display("turnout_position_stall_monitor_core regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic queue_word(input word_t w);
    pending_words.push_back(w);
    if (w.cmd == CMD_TICK || w.chan < CH) word_count++;
  endtask

  task automatic queue_tick(input logic [7:0] sp, input logic [7:0] dp, input logic drain);
    queue_word('{drain: drain, cmd: CMD_TICK, sp: sp, dp: dp, chan: 3'($urandom),
                 cur: 16'($urandom), tgt: 16'($urandom)});
  endtask

  task automatic queue_move(input logic [2:0] ch, input logic [15:0] cur,
                            input logic [15:0] tgt);
    queue_word('{drain: 1'b0, cmd: CMD_MOVE, sp: 8'($urandom), dp: 8'($urandom),
                 chan: ch, cur: cur, tgt: tgt});
  endtask

  task automatic queue_rest_tick(input int moving_ch, input logic drain);
    logic [7:0] sp, dp;
    logic       both;
    sp = 8'($urandom);
    dp = 8'($urandom);
    sp[CH-1:0] = rest_sp;
    dp[CH-1:0] = rest_dp;
    if (moving_ch >= 0) begin
      both = ($urandom_range(0, 7) == 0);
      sp[moving_ch] = both;
      dp[moving_ch] = both;
    end
    queue_tick(sp, dp, drain);
  endtask

  // Mostly complete point movements: start, travel with open contacts, settle.
  task automatic queue_random(input int unsigned count);
    int unsigned goal, sel, ch, other;
    logic [15:0] cur, tgt;
    goal = word_count + count;
    while (word_count < goal) begin
      if ($urandom_range(0, 9) < 7) begin
        ch  = $urandom_range(0, CH - 1);
        sel = $urandom_range(0, 5);
        cur = (sel == 0) ? 16'd0 : 16'($urandom_range(1, 65535));
        tgt = (sel == 1) ? 16'd0 : 16'($urandom_range(1, 65535));
        if (sel == 2) tgt = 16'(cur + $urandom_range(0, 24));
        queue_move(3'(ch), cur, tgt);
        repeat ($urandom_range(0, 12)) begin
          if ($urandom_range(0, 9) == 0) begin
            other = $urandom_range(0, CH - 1);
            if (other != ch) begin
              rest_sp[other] = ~rest_sp[other];
              rest_dp[other] = ~rest_sp[other];
            end
          end
          queue_rest_tick(ch, $urandom_range(0, 39) == 0);
        end
        rest_sp[ch] = 1'($urandom);
        rest_dp[ch] = ~rest_sp[ch];
        repeat ($urandom_range(1, 4)) queue_rest_tick(-1, 1'b0);
      end else if ($urandom_range(0, 1) == 0) begin
        queue_tick(8'($urandom), 8'($urandom), 1'b0);
      end else begin
        queue_move(3'($urandom), 16'($urandom), 16'($urandom));
      end
    end
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    case (idx)
      CFG_REPORT_PERIOD: period_ms  = val;
      CFG_UNKNOWN_LIMIT: unknown_ms = val;
      CFG_MIN_TRAVEL:    min_ms     = val;
      CFG_MAX_TRAVEL:    max_ms     = val;
      default:           margin_ms  = val;
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic program_limits(input logic [15:0] period, input logic [15:0] unknown,
                                input logic [15:0] lo, input logic [15:0] hi,
                                input logic [15:0] margin);
    write_reg(CFG_REPORT_PERIOD, period);
    write_reg(CFG_UNKNOWN_LIMIT, unknown);
    write_reg(CFG_MIN_TRAVEL, lo);
    write_reg(CFG_MAX_TRAVEL, hi);
    write_reg(CFG_MARGIN, margin);
  endtask

  // A movement start gives no report word, so the block may still be busy
  // after the last expected word; the settle time covers that.
  task automatic wait_idle();
    while (pending_words.size() != 0 || in_flight || expected_reports.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    in_if.valid            = 1'b0;
    in_if.cmd              = CMD_TICK;
    in_if.straight_pressed = '0;
    in_if.diverted_pressed = '0;
    in_if.channel          = '0;
    in_if.current_pwm      = '0;
    in_if.target_pwm       = '0;
    out_if.ready           = 1'b0;
    period_ms  = REPORT_PERIOD_RST;
    unknown_ms = UNKNOWN_LIMIT_RST;
    min_ms     = MIN_TRAVEL_RST;
    max_ms     = MAX_TRAVEL_RST;
    margin_ms  = MARGIN_RST;
    now_ms     = '0;
    for (int c = 0; c < CH; c++) begin
      start_ms[c]  = '0;
      limit_ms[c]  = '0;
      moving[c]    = 1'b0;
      rep_valid[c] = 1'b0;
      rep_pos[c]   = POS_STRAIGHT;
      rep_stat[c]  = STAT_OK;
      rep_time[c]  = '0;
    end
    rest_sp = '1;
    rest_dp = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: every position code, limit clamps and ignored channels.
    queue_tick(8'hFF, 8'h00, 1'b0);
    queue_tick(8'hFF, 8'h00, 1'b0);
    queue_tick(8'h00, 8'hFF, 1'b0);
    queue_tick(8'h00, 8'h00, 1'b0);
    queue_tick(8'hFF, 8'hFF, 1'b0);
    queue_tick(8'h05, 8'hF6, 1'b0);
    queue_move(3'd0, 16'd0, 16'd1500);
    queue_move(3'd1, 16'hFFFF, 16'd1);
    queue_move(3'd2, 16'd1000, 16'd1001);
    queue_move(3'd7, 16'hFFFF, 16'hFFFF);
    queue_move(3'd3, 16'd100, 16'd0);
    queue_tick(8'h00, 8'h00, 1'b0);
    queue_tick(8'h00, 8'h00, 1'b0);
    queue_tick(8'h07, 8'h00, 1'b0);
    queue_tick(8'h07, 8'h00, 1'b1);
    queue_move(3'd1, 16'hFFFF, 16'd0);
    queue_tick(8'h05, 8'h02, 1'b0);
    queue_tick(8'hF8, 8'h07, 1'b0);
    wait_idle();

    // Zero period, zero unknown limit and crossed clamps.
    program_limits(16'd0, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
    queue_move(3'd0, 16'd100, 16'd300);
    queue_move(3'd1, 16'd0, 16'd0);
    queue_move(3'd2, 16'd5, 16'd5);
    queue_tick(8'h07, 8'h00, 1'b0);
    queue_tick(8'h07, 8'h00, 1'b0);
    queue_random(40);
    wait_idle();

    program_limits(16'd3, 16'd4, 16'd1, 16'd6, 16'd2);
    queue_random(140);
    wait_idle();

    no_gaps = 1'b1;
    program_limits(16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF);
    queue_move(3'd1, 16'hFFFF, 16'd1);
    queue_move(3'd2, 16'd0, 16'd7);
    queue_tick(8'h00, 8'h00, 1'b0);
    queue_tick(8'h02, 8'h05, 1'b0);
    queue_random(60);
    wait_idle();

    no_gaps = 1'b0;
    program_limits(16'd1, 16'd0, 16'd0, 16'd3, 16'd0);
    queue_random(100);
    wait_idle();

    program_limits(REPORT_PERIOD_RST, UNKNOWN_LIMIT_RST, MIN_TRAVEL_RST, MAX_TRAVEL_RST,
                   MARGIN_RST);
    queue_random(60);
    wait_idle();

    if (errors == 0) begin
      $display("turnout_position_stall_monitor_core regression: pass");
    end else begin
      $display("turnout_position_stall_monitor_core regression: fail");
    end
    $finish;
  end

endmodule

/* files.f */
design/tpsm_pkg.sv
design/tpsm_if.sv
design/tpsm_alu.sv
design/turnout_position_stall_monitor_core.sv
sim/turnout_position_stall_monitor_core_tb.sv
